@@ design/spanning_forest_union_find_assert.svh @@
// Assertion macros for the spanning forest engine
`ifndef SPANNING_FOREST_UNION_FIND_ASSERT_SVH
`define SPANNING_FOREST_UNION_FIND_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SFUF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SFUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sfuf_pkg.sv @@
// Shared constants, types and helpers of the spanning forest engine
`default_nettype none

package sfuf_pkg;

  localparam int MAX_NODES  = 16384;
  localparam int NODE_W     = 15;
  localparam int WEIGHT_W   = 16;
  localparam int TOTAL_W    = 30;
  localparam int SUM_W      = 31;
  localparam int PROD_W     = NODE_W + WEIGHT_W;
  localparam int RANK_W     = 5;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int DIRTY_W    = $clog2(MAX_NODES + 1);
  localparam int ENTRY_W    = IDX_W + RANK_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [RANK_W-1:0]    RANK_ONE  = RANK_W'(1);
  localparam logic [RANK_W-1:0]    RANK_MAX  = RANK_W'(31);
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;
  localparam logic [DIRTY_W-1:0]   DIRTY_ALL = DIRTY_W'(MAX_NODES);

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIRPORT_COST = 1'b1;

  typedef struct packed {
    logic                present;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } item_t;

  typedef struct packed {
    logic               joined;
    logic               done;
    logic [TOTAL_W-1:0] total;
    logic [NODE_W-1:0]  count;
  } result_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] wr_data;
  } ram_req_t;

  function automatic logic [NODE_W-1:0] live_nodes(input logic [NODE_W-1:0] n);
    if (32'(n) > MAX_NODES) begin
      return NODE_W'(MAX_NODES);
    end
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] node_to_idx(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    return IDX_W'(m);
  endfunction

  function automatic logic [ENTRY_W-1:0] make_entry(input logic [IDX_W-1:0] parent,
                                                    input logic [RANK_W-1:0] rank);
    return {parent, rank};
  endfunction

endpackage

`default_nettype wire

@@ design/sfuf_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module sfuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/sfuf_ctrl.sv @@
// Union-find sequencer: finds, path compression, union, tally and table sweep
`default_nettype none

module sfuf_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             item_valid,
  input  wire sfuf_pkg::item_t                  item,
  input  wire logic [sfuf_pkg::NODE_W-1:0]      node_live,
  input  wire logic [sfuf_pkg::WEIGHT_W-1:0]    airport_cost,
  input  wire logic                             node_wr,
  input  wire logic [sfuf_pkg::NODE_W-1:0]      node_live_new,
  input  wire logic                             res_ready,
  input  wire logic [sfuf_pkg::ENTRY_W-1:0]     ram_rdata,
  output      sfuf_pkg::ram_req_t               ram_req,
  output      logic                             idle,
  output      logic                             res_load,
  output      sfuf_pkg::result_t                res
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_CMP_RD,
    S_CMP_WR,
    S_UNION,
    S_RANK,
    S_FIN,
    S_SUM,
    S_EMIT
  } state_t;

  state_t                            state_r;
  logic                              side_r;
  logic [sfuf_pkg::IDX_W-1:0]        x_r;
  logic [sfuf_pkg::IDX_W-1:0]        a_idx_r;
  logic [sfuf_pkg::IDX_W-1:0]        b_idx_r;
  logic [sfuf_pkg::IDX_W-1:0]        root_a_r;
  logic [sfuf_pkg::IDX_W-1:0]        root_b_r;
  logic [sfuf_pkg::RANK_W-1:0]       rank_a_r;
  logic [sfuf_pkg::RANK_W-1:0]       rank_b_r;
  logic [sfuf_pkg::WEIGHT_W-1:0]     weight_r;
  logic                              done_r;
  logic                              joined_r;
  logic [sfuf_pkg::SUM_W-1:0]        sum_r;
  logic [sfuf_pkg::NODE_W-1:0]       cnt_r;
  logic [sfuf_pkg::PROD_W-1:0]       prod_r;
  logic [sfuf_pkg::TOTAL_W-1:0]      total_r;
  logic [sfuf_pkg::IDX_W-1:0]        sweep_r;
  logic [sfuf_pkg::DIRTY_W-1:0]      dirty_r;

  logic [sfuf_pkg::IDX_W-1:0]        rd_parent;
  logic [sfuf_pkg::RANK_W-1:0]       rd_rank;
  logic [sfuf_pkg::IDX_W-1:0]        root_cur;
  logic                              a_ok;
  logic                              b_ok;
  logic                              edge_ok;
  logic [sfuf_pkg::DIRTY_W-1:0]      wr_top;
  logic [sfuf_pkg::SUM_W:0]          grand;
  logic [sfuf_pkg::RANK_W-1:0]       rank_inc;

  assign rd_parent = ram_rdata[sfuf_pkg::ENTRY_W-1:sfuf_pkg::RANK_W];
  assign rd_rank   = ram_rdata[sfuf_pkg::RANK_W-1:0];
  assign root_cur  = side_r ? root_b_r : root_a_r;
  assign a_ok      = (item.node_a != '0) && (item.node_a <= node_live);
  assign b_ok      = (item.node_b != '0) && (item.node_b <= node_live);
  assign edge_ok   = item.present && (item.weight < airport_cost) && a_ok && b_ok;
  assign wr_top    = sfuf_pkg::DIRTY_W'(ram_req.addr) + sfuf_pkg::DIRTY_W'(1);
  assign grand     = (sfuf_pkg::SUM_W+1)'(sum_r) + (sfuf_pkg::SUM_W+1)'(prod_r);
  assign rank_inc  = (rank_a_r < sfuf_pkg::RANK_MAX) ? rank_a_r + sfuf_pkg::RANK_ONE
                                                      : rank_a_r;

  assign idle     = (state_r == S_IDLE);
  assign res_load = (state_r == S_EMIT) && res_ready;

  always_comb begin
    res.joined = joined_r;
    res.done   = done_r;
    res.total  = total_r;
    res.count  = done_r ? cnt_r : '0;
  end

  always_comb begin
    ram_req.rd_en   = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.addr    = x_r;
    ram_req.wr_data = sfuf_pkg::make_entry(root_cur, rd_rank);
    case (state_r)
      S_SWEEP: begin
        ram_req.wr_en   = (dirty_r != '0);
        ram_req.addr    = sweep_r;
        ram_req.wr_data = sfuf_pkg::make_entry(sweep_r, sfuf_pkg::RANK_ONE);
      end
      S_FIND_RD: begin
        ram_req.rd_en = 1'b1;
      end
      S_CMP_RD: begin
        ram_req.rd_en = (x_r != root_cur);
      end
      S_CMP_WR: begin
        ram_req.wr_en = 1'b1;
      end
      S_UNION: begin
        ram_req.wr_en = (root_a_r != root_b_r);
        if (rank_a_r < rank_b_r) begin
          ram_req.addr    = root_a_r;
          ram_req.wr_data = sfuf_pkg::make_entry(root_b_r, rank_a_r);
        end else begin
          ram_req.addr    = root_b_r;
          ram_req.wr_data = sfuf_pkg::make_entry(root_a_r, rank_b_r);
        end
      end
      S_RANK: begin
        ram_req.wr_en   = 1'b1;
        ram_req.addr    = root_a_r;
        ram_req.wr_data = sfuf_pkg::make_entry(root_a_r, rank_inc);
      end
      default: begin
        ram_req.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      sweep_r <= '0;
      dirty_r <= sfuf_pkg::DIRTY_ALL;
      sum_r   <= '0;
      cnt_r   <= sfuf_pkg::NODE_W'(1);
    end else begin
      if (ram_req.wr_en && (state_r != S_SWEEP) && (wr_top > dirty_r)) begin
        dirty_r <= wr_top;
      end
      case (state_r)
        S_SWEEP: begin
          if (dirty_r == '0) begin
            sweep_r <= '0;
            state_r <= S_IDLE;
          end else if (sfuf_pkg::DIRTY_W'(sweep_r) + sfuf_pkg::DIRTY_W'(1) == dirty_r) begin
            sweep_r <= '0;
            dirty_r <= '0;
            state_r <= S_IDLE;
          end else begin
            sweep_r <= sweep_r + sfuf_pkg::IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            a_idx_r  <= sfuf_pkg::node_to_idx(item.node_a);
            b_idx_r  <= sfuf_pkg::node_to_idx(item.node_b);
            x_r      <= sfuf_pkg::node_to_idx(item.node_a);
            weight_r <= item.weight;
            done_r   <= item.last || !item.present;
            joined_r <= 1'b0;
            total_r  <= '0;
            side_r   <= 1'b0;
            state_r  <= edge_ok ? S_FIND_RD : S_FIN;
          end
        end
        S_FIND_RD: begin
          state_r <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (rd_parent == x_r) begin
            if (side_r) begin
              root_b_r <= x_r;
              rank_b_r <= rd_rank;
              x_r      <= b_idx_r;
            end else begin
              root_a_r <= x_r;
              rank_a_r <= rd_rank;
              x_r      <= a_idx_r;
            end
            state_r <= S_CMP_RD;
          end else begin
            x_r     <= rd_parent;
            state_r <= S_FIND_RD;
          end
        end
        S_CMP_RD: begin
          if (x_r == root_cur) begin
            if (side_r) begin
              state_r <= S_UNION;
            end else begin
              side_r  <= 1'b1;
              x_r     <= b_idx_r;
              state_r <= S_FIND_RD;
            end
          end else begin
            state_r <= S_CMP_WR;
          end
        end
        S_CMP_WR: begin
          x_r     <= rd_parent;
          state_r <= S_CMP_RD;
        end
        S_UNION: begin
          if (root_a_r == root_b_r) begin
            state_r <= S_FIN;
          end else begin
            joined_r <= 1'b1;
            sum_r    <= sum_r + sfuf_pkg::SUM_W'(weight_r);
            if (cnt_r != '0) begin
              cnt_r <= cnt_r - sfuf_pkg::NODE_W'(1);
            end
            state_r <= (rank_a_r == rank_b_r) ? S_RANK : S_FIN;
          end
        end
        S_RANK: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          prod_r  <= sfuf_pkg::PROD_W'(cnt_r) * sfuf_pkg::PROD_W'(airport_cost);
          state_r <= done_r ? S_SUM : S_EMIT;
        end
        S_SUM: begin
          if (grand > (sfuf_pkg::SUM_W+1)'(sfuf_pkg::TOTAL_MAX)) begin
            total_r <= sfuf_pkg::TOTAL_MAX;
          end else begin
            total_r <= grand[sfuf_pkg::TOTAL_W-1:0];
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            if (done_r) begin
              sum_r   <= '0;
              cnt_r   <= node_live;
              state_r <= S_SWEEP;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (node_wr) begin
        sum_r <= '0;
        cnt_r <= node_live_new;
        if (state_r == S_IDLE) begin
          state_r <= S_SWEEP;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/spanning_forest_union_find.sv @@
// Top level of the Kruskal spanning forest engine with airport costs
//
// Input channel (in_*): one beat is one edge, sorted by ascending weight.
// in_edge_present low closes an empty case; in_last_edge high closes the case
// after the edge is applied. Result channel (out_*): exactly one beat per
// input beat. out_joined says the edge merged two sets; on a closing beat
// out_case_done is high and out_total_cost / out_airport_count hold the case
// answer, otherwise both are zero.
// The node table has one address shared by reads and writes. A live edge
// runs a find from each end, visiting every node up to the root, each find
// followed by a path compression pass that rewrites the links on the way,
// then the union, with a rank update when the ranks tie. An ignored edge
// goes straight to the result. A closing beat adds the airport sum, then a
// sweep of the node table over every entry up to the highest one written
// since the last sweep. Otherwise the engine is ready for the next edge in
// the cycle after the result is loaded. After reset the sweep covers all 16384
// entries with in_stall high. Writing node_count resets the running cost and
// count and, while idle, starts a sweep up to the highest entry written. Results
// sit in an output register: a stalled result holds while the next edge is
// accepted, and the engine waits only when a new result is ready and the register is still full.
`default_nettype none

module spanning_forest_union_find (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                in_edge_present,
  input  wire logic [sfuf_pkg::NODE_W-1:0]         in_node_a,
  input  wire logic [sfuf_pkg::NODE_W-1:0]         in_node_b,
  input  wire logic [sfuf_pkg::WEIGHT_W-1:0]       in_edge_weight,
  input  wire logic                                in_last_edge,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic                                out_joined,
  output      logic                                out_case_done,
  output      logic [sfuf_pkg::TOTAL_W-1:0]        out_total_cost,
  output      logic [sfuf_pkg::NODE_W-1:0]         out_airport_count,
  input  wire logic                                cfg_we,
  input  wire logic [sfuf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sfuf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [sfuf_pkg::NODE_W-1:0]   node_count_r;
  logic [sfuf_pkg::WEIGHT_W-1:0] airport_cost_r;
  logic                          out_valid_r;
  sfuf_pkg::result_t             out_res_r;

  logic [sfuf_pkg::NODE_W-1:0]   node_live;
  logic [sfuf_pkg::NODE_W-1:0]   node_live_new;
  logic                          node_wr;
  logic                          in_accept;
  logic                          ctrl_idle;
  logic                          res_load;
  logic                          res_ready;
  sfuf_pkg::result_t             res;
  sfuf_pkg::item_t               item;
  sfuf_pkg::ram_req_t            ram_req;
  logic [sfuf_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                          open_beat;
  logic                          done_beat;
  logic                          open_zero;

  assign node_live     = sfuf_pkg::live_nodes(node_count_r);
  assign node_live_new = sfuf_pkg::live_nodes(cfg_wdata[sfuf_pkg::NODE_W-1:0]);
  assign node_wr       = cfg_we && (cfg_index == sfuf_pkg::CFG_NODE_COUNT);
  assign in_stall      = !ctrl_idle;
  assign in_accept     = in_valid && !in_stall;
  assign res_ready     = !out_valid_r || !out_stall;

  always_comb begin
    item.present = in_edge_present;
    item.node_a  = in_node_a;
    item.node_b  = in_node_b;
    item.weight  = in_edge_weight;
    item.last    = in_last_edge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r   <= sfuf_pkg::NODE_W'(1);
      airport_cost_r <= sfuf_pkg::WEIGHT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sfuf_pkg::CFG_NODE_COUNT: begin
          node_count_r <= cfg_wdata[sfuf_pkg::NODE_W-1:0];
        end
        sfuf_pkg::CFG_AIRPORT_COST: begin
          airport_cost_r <= cfg_wdata[sfuf_pkg::WEIGHT_W-1:0];
        end
        default: begin
          airport_cost_r <= airport_cost_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_joined        = out_res_r.joined;
  assign out_case_done     = out_res_r.done;
  assign out_total_cost    = out_res_r.total;
  assign out_airport_count = out_res_r.count;

  sfuf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (in_accept),
    .item          (item),
    .node_live     (node_live),
    .airport_cost  (airport_cost_r),
    .node_wr       (node_wr),
    .node_live_new (node_live_new),
    .res_ready     (res_ready),
    .ram_rdata     (ram_rdata),
    .ram_req       (ram_req),
    .idle          (ctrl_idle),
    .res_load      (res_load),
    .res           (res)
  );

  sfuf_ram #(
    .WIDTH (sfuf_pkg::ENTRY_W),
    .DEPTH (sfuf_pkg::MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_req.wr_en),
    .waddr (ram_req.addr),
    .wdata (ram_req.wr_data),
    .re    (ram_req.rd_en),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

  assign open_beat = out_valid && !out_case_done;
  assign done_beat = out_valid && out_case_done;
  assign open_zero = (out_total_cost == '0) && (out_airport_count == '0);

`include "spanning_forest_union_find_assert.svh"

  `SFUF_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "second edge taken at once")
  `SFUF_ASSERT_NOW(a_ram_one_access, ram_req.rd_en, !ram_req.wr_en, "read and write at once")
  `SFUF_ASSERT_NOW(a_open_case_zero, open_beat, open_zero, "open case reports an answer")
  `SFUF_ASSERT_NOW(a_count_bound, done_beat, out_airport_count <= node_live, "count too high")

endmodule

`default_nettype wire
